### hdl/wamt_pkg.sv
// Package for the weekly alarm match table.
// Holds the opcodes, status codes, time limits, the query word type handed along the cell row and the table write type.
// No dependencies.
`default_nettype none

package wamt_pkg;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [4:0] HOURS_PER_DAY    = 5'd24;
	localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;

	// Query word moving one cell per cycle along the row while the row is not held.
	typedef struct packed {
		logic       valid;
		logic       check;
		logic [2:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [1:0] status;
		logic       fired;
		logic [3:0] index;
	} wamt_token_t;

	// Table write broadcast to every cell; the cell at the fill position takes it.
	typedef struct packed {
		logic       en;
		logic [6:0] days;
		logic [4:0] hour;
		logic [5:0] minute;
	} wamt_write_t;

endpackage

`default_nettype wire

### hdl/weekly_alarm_match_table.sv
// Weekly alarm match table: a row of MAX_ALARMS cells, one entry each.
// Every word runs the full row, one cell per cycle while the row is not held, and is then
// registered at the output; the next word is taken only after the previous one leaves the row.
// A result waiting at the output holds the row but not the input.
// Reset empties the table and the row; stored entries themselves are not cleared.
// Depends on wamt_pkg and wamt_cell.
`default_nettype none

module weekly_alarm_match_table
	import wamt_pkg::*;
#(
	parameter int MAX_ALARMS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// alarm_days[6:0], alarm_hour[11:7], alarm_minute[17:12],
	// now_weekday[20:18], now_hour[25:21], now_minute[31:26]
	input  wire logic [31:0] s_tdata,
	// opcode[0]
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[1:0], fired[2], fired_index[6:3], zero[7]
	output logic [7:0]       m_tdata
);

	localparam int CNT_W = $clog2(MAX_ALARMS + 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ALARMS);

	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic             accept;
	logic             advance;
	logic             out_load;
	logic             time_ok;
	logic [1:0]       add_status;
	logic [6:0]       in_days;
	logic [4:0]       in_ahour;
	logic [5:0]       in_amin;
	logic [2:0]       in_nday;
	logic [4:0]       in_nhour;
	logic [5:0]       in_nmin;
	logic [1:0]       status_q;
	logic             fired_q;
	logic [3:0]       index_q;
	wamt_write_t      wr;
	wamt_token_t      tok_head;
	wamt_token_t      chain [MAX_ALARMS+1];

	assign in_days  = s_tdata[6:0];
	assign in_ahour = s_tdata[11:7];
	assign in_amin  = s_tdata[17:12];
	assign in_nday  = s_tdata[20:18];
	assign in_nhour = s_tdata[25:21];
	assign in_nmin  = s_tdata[31:26];

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;

	assign time_ok = in_ahour < HOURS_PER_DAY && in_amin < MINUTES_PER_HOUR;
	always_comb begin
		if (!time_ok) begin
			add_status = ST_INVALID;
		end else if (count_q >= FULL_COUNT) begin
			add_status = ST_FULL;
		end else begin
			add_status = ST_OK;
		end
	end

	assign wr.en     = accept && s_tuser == OP_ADD && add_status == ST_OK;
	assign wr.days   = in_days;
	assign wr.hour   = in_ahour;
	assign wr.minute = in_amin;

	always_comb begin
		tok_head        = '0;
		tok_head.valid  = accept;
		tok_head.check  = s_tuser == OP_CHECK;
		tok_head.day    = in_nday;
		tok_head.hour   = in_nhour;
		tok_head.minute = in_nmin;
		tok_head.status = (s_tuser == OP_ADD) ? add_status : ST_OK;
	end

	assign chain[0] = tok_head;

	// Hold the row while its finished word cannot move to the output.
	assign advance  = !(chain[MAX_ALARMS].valid && m_tvalid && !m_tready);
	assign out_load = chain[MAX_ALARMS].valid && advance;

	for (genvar i = 0; i < MAX_ALARMS; i++) begin : g_cell
		wamt_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.count   (count_q),
			.wr      (wr),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			busy_q   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (wr.en) begin
				count_q <= count_q + 1'b1;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (out_load) begin
				busy_q <= 1'b0;
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= chain[MAX_ALARMS].status;
			fired_q  <= chain[MAX_ALARMS].fired;
			index_q  <= chain[MAX_ALARMS].index;
		end
	end

	assign m_tdata = {1'b0, index_q, fired_q, status_q};

endmodule

`default_nettype wire

### hdl/wamt_cell.sv
// One table entry of the weekly alarm match table, with its stage of the query row.
// Depends on wamt_pkg.
`default_nettype none

module wamt_cell
	import wamt_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic [CNT_W-1:0] count,
	input  wire wamt_write_t      wr,
	input  wire wamt_token_t      tok_in,
	output wamt_token_t           tok_out
);

	localparam logic [CNT_W-1:0] SLOT     = CNT_W'(INDEX);
	localparam logic [3:0]       CELL_IDX = 4'(INDEX);

	logic [6:0]  days_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [7:0]  days_ext;
	logic        occupied;
	logic        hit;
	wamt_token_t tok_next;
	wamt_token_t tok_q;

	always_ff @(posedge clk) begin
		if (wr.en && count == SLOT) begin
			days_q   <= wr.days;
			hour_q   <= wr.hour;
			minute_q <= wr.minute;
		end
	end

	// Weekday 7 lands on the padding bit and never matches.
	assign days_ext = {1'b0, days_q};
	assign occupied = count > SLOT;
	assign hit = tok_in.valid && tok_in.check && occupied && days_ext[tok_in.day]
		&& hour_q == tok_in.hour && minute_q == tok_in.minute;

	always_comb begin
		tok_next = tok_in;
		if (hit) begin
			tok_next.fired = 1'b1;
			tok_next.index = CELL_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (advance) begin
			tok_q <= tok_next;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking bench for weekly_alarm_match_table: directed and random add and check words.
// A scoreboard class predicts every result word; depends on wamt_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
	import wamt_pkg::*;

	localparam int TABLE_DEPTH  = 16;
	localparam int RANDOM_WORDS = 1100;
	localparam int CALM_WORDS   = 150;
	localparam int TAIL_CYCLES  = 3 * (TABLE_DEPTH + 2);
	localparam int CYCLE_LIMIT  = 250000;
	localparam logic [2:0] NO_DAY = 3'd7;

	typedef struct packed {
		logic [1:0] status;
		logic       fired;
		logic [3:0] index;
	} alarm_result_t;

	class alarm_scoreboard;
		logic [6:0] day_mask[TABLE_DEPTH];
		logic [4:0] hour_of[TABLE_DEPTH];
		logic [5:0] minute_of[TABLE_DEPTH];
		int filled;
		int failures;
		alarm_result_t due[$];

		function new();
			filled = 0;
			failures = 0;
		endfunction

		// Work out the answer to an accepted word and update the table copy.
		function void note_word(logic op, logic [6:0] days, logic [4:0] ahour,
				logic [5:0] amin, logic [2:0] nday, logic [4:0] nhour, logic [5:0] nmin);
			alarm_result_t r;
			r = '0;
			r.status = ST_OK;
			if (op == OP_ADD) begin
				if (ahour >= HOURS_PER_DAY || amin >= MINUTES_PER_HOUR) begin
					r.status = ST_INVALID;
				end else if (filled >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					day_mask[filled] = days;
					hour_of[filled] = ahour;
					minute_of[filled] = amin;
					filled++;
				end
			end else begin
				// later entries override earlier ones: keep the last match
				for (int i = 0; i < filled; i++) begin
					if (nday != NO_DAY && day_mask[i][nday] && hour_of[i] == nhour
							&& minute_of[i] == nmin) begin
						r.fired = 1'b1;
						r.index = i[3:0];
					end
				end
			end
			due.push_back(r);
		endfunction

		function void check_result(logic [7:0] word);
			alarm_result_t want;
			if (due.size() == 0) begin
				failures++;
				$display("%0t: result word %h arrived with nothing expected", $time, word);
				return;
			end
			want = due.pop_front();
			if (word[1:0] !== want.status) begin
				failures++;
				$display("%0t: status expected %0d actual %0d", $time, want.status, word[1:0]);
			end
			if (word[2] !== want.fired) begin
				failures++;
				$display("%0t: fired expected %0d actual %0d", $time, want.fired, word[2]);
			end
			if (word[6:3] !== want.index) begin
				failures++;
				$display("%0t: fired_index expected %0d actual %0d", $time, want.index, word[6:3]);
			end
		endfunction

		function int open_count();
			return due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;

	alarm_scoreboard board;
	int cycles = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	bit calm = 1'b0;

	weekly_alarm_match_table #(.MAX_ALARMS(TABLE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Present one word and hold it until the block takes it.
	task automatic send_word(logic op, logic [6:0] days, logic [4:0] ahour, logic [5:0] amin,
			logic [2:0] nday, logic [4:0] nhour, logic [5:0] nmin);
		int gap;
		s_tuser <= op;
		s_tdata <= {nmin, nhour, nday, amin, ahour, days};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_word(op, days, ahour, amin, nday, nhour, nmin);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Mostly well-formed traffic: valid adds and checks aimed at stored entries.
	task automatic random_word();
		int pick;
		int slot;
		int tries;
		logic op;
		logic [6:0] days;
		logic [4:0] ahour;
		logic [4:0] nhour;
		logic [5:0] amin;
		logic [5:0] nmin;
		logic [2:0] nday;
		pick = $urandom_range(0, 99);
		days = 7'($urandom);
		ahour = 5'($urandom);
		amin = 6'($urandom);
		nday = 3'($urandom);
		nhour = 5'($urandom);
		nmin = 6'($urandom);
		op = OP_CHECK;
		if (pick < 22) begin
			op = OP_ADD;
			ahour = 5'($urandom_range(0, 23));
			amin = 6'($urandom_range(0, 59));
			// duplicate times make the last-match rule matter
			if (board.filled > 0 && $urandom_range(0, 2) == 0) begin
				slot = $urandom_range(0, board.filled - 1);
				ahour = board.hour_of[slot];
				amin = board.minute_of[slot];
			end
		end else if (pick < 28) begin
			op = OP_ADD;
			case ($urandom_range(0, 2))
				0: ahour = 5'($urandom_range(24, 31));
				1: amin = 6'($urandom_range(60, 63));
				default: begin
					ahour = 5'($urandom_range(24, 31));
					amin = 6'($urandom_range(60, 63));
				end
			endcase
		end else if (pick < 85 && board.filled > 0) begin
			slot = $urandom_range(0, board.filled - 1);
			nhour = board.hour_of[slot];
			nmin = board.minute_of[slot];
			nday = 3'($urandom_range(0, 6));
			tries = 0;
			while (board.day_mask[slot] != 7'd0 && !board.day_mask[slot][nday] && tries < 8) begin
				nday = 3'($urandom_range(0, 6));
				tries++;
			end
			if ($urandom_range(0, 9) == 0)
				nmin = nmin + 6'd1;
			if ($urandom_range(0, 19) == 0)
				nday = NO_DAY;
		end else if (pick < 95) begin
			nday = 3'($urandom_range(0, 7));
			nhour = 5'($urandom_range(0, 23));
			nmin = 6'($urandom_range(0, 59));
		end
		send_word(op, days, ahour, amin, nday, nhour, nmin);
	endtask

	// Result side: take words, stall in random bursts.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			if (!arst_n || stall_left > 0) begin
				if (stall_left > 0)
					stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 11) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		board = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= OP_ADD;
		s_tdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 30;
		stall_pct = 20;
		send_word(OP_CHECK, 7'h00, 5'd0, 6'd0, 3'd0, 5'd0, 6'd0);       // empty table
		send_word(OP_ADD, 7'h7f, 5'd0, 6'd0, 3'd7, 5'd31, 6'd63);        // entry 0
		send_word(OP_ADD, 7'h7f, 5'd24, 6'd0, 3'd0, 5'd0, 6'd0);         // hour too big
		send_word(OP_ADD, 7'h55, 5'd31, 6'd0, 3'd0, 5'd0, 6'd0);
		send_word(OP_ADD, 7'h2a, 5'd0, 6'd60, 3'd0, 5'd0, 6'd0);         // minute too big
		send_word(OP_ADD, 7'h7f, 5'd23, 6'd63, 3'd0, 5'd0, 6'd0);
		send_word(OP_ADD, 7'h00, 5'd23, 6'd59, 3'd0, 5'd0, 6'd0);        // entry 1, never fires
		send_word(OP_ADD, 7'h41, 5'd23, 6'd59, 3'd0, 5'd0, 6'd0);        // entry 2, weekdays 0 and 6
		send_word(OP_ADD, 7'h7f, 5'd0, 6'd0, 3'd0, 5'd0, 6'd0);          // entry 3, same as 0
		send_word(OP_CHECK, 7'h7f, 5'd31, 6'd63, 3'd0, 5'd0, 6'd0);      // last match wins
		send_word(OP_CHECK, 7'h00, 5'd0, 6'd0, 3'd6, 5'd23, 6'd59);
		send_word(OP_CHECK, 7'h00, 5'd0, 6'd0, 3'd3, 5'd23, 6'd59);
		send_word(OP_CHECK, 7'h00, 5'd0, 6'd0, NO_DAY, 5'd0, 6'd0);     // no day
		send_word(OP_CHECK, 7'h00, 5'd0, 6'd0, 3'd5, 5'd31, 6'd63);      // time out of range
		send_word(OP_CHECK, 7'h00, 5'd0, 6'd0, 3'd2, 5'd0, 6'd60);
		send_word(OP_ADD, 7'h14, 5'd12, 6'd30, 3'd0, 5'd0, 6'd0);        // entry 4
		send_word(OP_CHECK, 7'h00, 5'd0, 6'd0, 3'd4, 5'd12, 6'd30);
		send_word(OP_CHECK, 7'h00, 5'd0, 6'd0, 3'd2, 5'd12, 6'd31);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// change the idling mix now and then, quiet stretches included
			if (n % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 15;
					default: gap_pct = 50;
				endcase
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 40;
				endcase
			end
			if (n == RANDOM_WORDS - CALM_WORDS)
				calm = 1'b1;
			random_word();
		end
		s_tvalid <= 1'b0;

		while (board.open_count() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.failures == 0 && board.open_count() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
